// ===== hdl/iat_pkg.sv =====
// ----------------------------------------------------------------------------
// Ignition advance timer package
// Shared types, register indexes, band codes and fixed constants.
// ----------------------------------------------------------------------------
package iat_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned TS_W      = 32;
    localparam int unsigned DEG_W     = 9;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE  = 2'd2;

    // Configuration reset values.
    localparam logic [TS_W-1:0]  LOW_BAND_RESET = 32'd30000;
    localparam logic [TS_W-1:0]  LIMIT_RESET    = 32'd6666;
    localparam logic [DEG_W-1:0] ADVANCE_RESET  = 9'd5;

    // Speed band codes.
    localparam logic [1:0] BAND_LOW   = 2'd0;
    localparam logic [1:0] BAND_TIMED = 2'd1;
    localparam logic [1:0] BAND_LIMIT = 2'd2;

    // Advance unit: two stages for the average, two for the division by 360,
    // one for the multiply and one for the saturating subtract.
    localparam int unsigned DEG_PER_REV  = 360;
    localparam int unsigned QUOT360_W    = 24;
    localparam int unsigned PROD_W       = QUOT360_W + DEG_W;
    localparam int unsigned ADV_PIPE_LAT = 6;

    // One input beat.
    typedef struct packed {
        logic            sensor_level;
        logic [TS_W-1:0] now_us;
    } iat_in_t;

    // One result beat.
    typedef struct packed {
        logic            ignition_level;
        logic [1:0]      speed_band;
        logic [TS_W-1:0] advance_time_us;
    } iat_out_t;

    // Item as classified by the front end.
    typedef struct packed {
        logic            sensor_level;
        logic [TS_W-1:0] now_us;
        logic [1:0]      speed_band;
    } iat_tag_t;

    // Queue entry handed to the back end.
    typedef struct packed {
        iat_tag_t        tag;
        logic [TS_W-1:0] advance_time_us;
    } iat_cmd_t;

endpackage

// ===== hdl/iat_front.sv =====
// ----------------------------------------------------------------------------
// Ignition advance timer front end
// Detects revolution ends, keeps the period window and its running total,
// and classifies each beat into a speed band.
// ----------------------------------------------------------------------------
module iat_front
    import iat_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 5,
    parameter int unsigned TOTAL_W      = 35
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_beat,
    input  iat_in_t            sample,
    input  logic [TS_W-1:0]    low_band_period,
    input  logic [TS_W-1:0]    limit_period,
    output logic               item_valid,
    output iat_tag_t           item,
    output logic [TOTAL_W-1:0] total
);

    localparam int unsigned PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);

    logic [TS_W-1:0]    window_reg [WINDOW_DEPTH];
    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   ptr_next;
    logic               armed_reg;
    logic [TS_W-1:0]    edge_time_reg;
    logic [TS_W-1:0]    band_period_reg;
    logic [TS_W-1:0]    band_period_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic               item_valid_reg;
    iat_tag_t           item_reg;

    logic               closing;
    logic [TS_W-1:0]    period;
    logic [1:0]         band;

    // A low level after a high phase closes one revolution.
    assign closing = !sample.sensor_level && armed_reg;
    assign period  = sample.now_us - edge_time_reg;

    // Running total swaps the oldest period for the new one.
    assign total_next = total_reg - TOTAL_W'(window_reg[ptr_reg]) + TOTAL_W'(period);
    assign ptr_next   = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;

    // A zero period still enters the window but leaves the band period alone.
    assign band_period_next = (closing && (period != '0)) ? period : band_period_reg;

    // Band classification; the low band test wins.
    always_comb
    begin
        if ((band_period_next == '0) || (band_period_next > low_band_period)) begin
            band = BAND_LOW;
        end else if (band_period_next > limit_period) begin
            band = BAND_TIMED;
        end else begin
            band = BAND_LIMIT;
        end
    end

    // Revolution state and window.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            armed_reg       <= 1'b0;
            edge_time_reg   <= '0;
            band_period_reg <= '0;
            ptr_reg         <= '0;
            total_reg       <= '0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                window_reg[i] <= '0;
            end
        end else if (sample_beat) begin
            if (sample.sensor_level) begin
                armed_reg <= 1'b1;
            end else if (armed_reg) begin
                armed_reg           <= 1'b0;
                edge_time_reg       <= sample.now_us;
                band_period_reg     <= band_period_next;
                ptr_reg             <= ptr_next;
                total_reg           <= total_next;
                window_reg[ptr_reg] <= period;
            end
        end
    end

    // Beat valid toward the advance unit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
        end else begin
            item_valid_reg <= sample_beat;
        end
    end

    // Classified item payload.
    always_ff @(posedge clk)
    begin
        if (sample_beat) begin
            item_reg.sensor_level <= sample.sensor_level;
            item_reg.now_us       <= sample.now_us;
            item_reg.speed_band   <= band;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;
    assign total      = total_reg;

endmodule

// ===== hdl/iat_adv.sv =====
// ----------------------------------------------------------------------------
// Ignition advance timer advance unit
// Pipelined average, divide by 360, multiply by advance degrees and
// saturating subtract, one item per cycle.
// ----------------------------------------------------------------------------
module iat_adv
    import iat_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 5,
    parameter int unsigned TOTAL_W      = 35
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  iat_tag_t           item,
    input  logic [TOTAL_W-1:0] total,
    input  logic [DEG_W-1:0]   advance_degrees,
    output logic               cmd_valid,
    output iat_cmd_t           cmd
);

    localparam int unsigned PIPE_LAT = ADV_PIPE_LAT;

    // Average: the total times a rounded-up reciprocal of the window depth,
    // exact for every total below two to the power TOTAL_W.
    localparam int unsigned A_SHIFT = TOTAL_W + $clog2(WINDOW_DEPTH);
    localparam int unsigned A_HALF  = (TOTAL_W + 2) / 2;
    localparam int unsigned A_PP_W  = 2 * A_HALF;
    localparam int unsigned A_SUM_W = 4 * A_HALF;
    localparam logic [63:0] A_RECIP = ((64'd1 << A_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1)
                                      / 64'(WINDOW_DEPTH);
    localparam logic [A_HALF-1:0] A_RECIP_HI = A_HALF'(A_RECIP >> A_HALF);
    localparam logic [A_HALF-1:0] A_RECIP_LO = A_HALF'(A_RECIP);

    // Division by 360 with the same scheme on the 32-bit average.
    localparam int unsigned B_SHIFT = TS_W + $clog2(DEG_PER_REV);
    localparam int unsigned B_HALF  = (TS_W + 2) / 2;
    localparam int unsigned B_PP_W  = 2 * B_HALF;
    localparam int unsigned B_SUM_W = 4 * B_HALF;
    localparam logic [63:0] B_RECIP = ((64'd1 << B_SHIFT) + 64'(DEG_PER_REV) - 64'd1)
                                      / 64'(DEG_PER_REV);
    localparam logic [B_HALF-1:0] B_RECIP_HI = B_HALF'(B_RECIP >> B_HALF);
    localparam logic [B_HALF-1:0] B_RECIP_LO = B_HALF'(B_RECIP);

    logic                 vld_reg [1:PIPE_LAT];
    iat_tag_t             tag_reg [1:PIPE_LAT];

    logic [A_HALF-1:0]    a_num_hi;
    logic [A_HALF-1:0]    a_num_lo;
    logic [A_PP_W-1:0]    a_pp_reg [4];
    logic [A_SUM_W-1:0]   a_sum;
    logic [TS_W-1:0]      avg_reg;
    logic [B_HALF-1:0]    b_num_hi;
    logic [B_HALF-1:0]    b_num_lo;
    logic [B_PP_W-1:0]    b_pp_reg [4];
    logic [TS_W-1:0]      b_avg_reg;
    logic [B_SUM_W-1:0]   b_sum;
    logic [QUOT360_W-1:0] quot_reg;
    logic [TS_W-1:0]      q_avg_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [TS_W-1:0]      m_avg_reg;
    logic [TS_W-1:0]      adv_reg;

    // Valid and item tag travel alongside the arithmetic.
    for (genvar k = 0; k < PIPE_LAT; k++) begin : g_tag
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                vld_reg[k+1] <= 1'b0;
            end else begin
                vld_reg[k+1] <= (k == 0) ? item_valid : vld_reg[(k == 0) ? 1 : k];
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[k+1] <= (k == 0) ? item : tag_reg[(k == 0) ? 1 : k];
        end
    end

    // Average, first stage: four half-width partial products.
    assign {a_num_hi, a_num_lo} = A_PP_W'(total);

    always_ff @(posedge clk)
    begin
        a_pp_reg[0] <= A_PP_W'(a_num_lo) * A_PP_W'(A_RECIP_LO);
        a_pp_reg[1] <= A_PP_W'(a_num_lo) * A_PP_W'(A_RECIP_HI);
        a_pp_reg[2] <= A_PP_W'(a_num_hi) * A_PP_W'(A_RECIP_LO);
        a_pp_reg[3] <= A_PP_W'(a_num_hi) * A_PP_W'(A_RECIP_HI);
    end

    // Average, second stage: sum the partial products and drop the fraction.
    assign a_sum = A_SUM_W'(a_pp_reg[0])
                 + (A_SUM_W'(a_pp_reg[1]) << A_HALF)
                 + (A_SUM_W'(a_pp_reg[2]) << A_HALF)
                 + (A_SUM_W'(a_pp_reg[3]) << A_PP_W);

    always_ff @(posedge clk)
    begin
        avg_reg <= a_sum[A_SHIFT +: TS_W];
    end

    // Average divided by 360, first stage: partial products.
    assign {b_num_hi, b_num_lo} = B_PP_W'(avg_reg);

    always_ff @(posedge clk)
    begin
        b_pp_reg[0] <= B_PP_W'(b_num_lo) * B_PP_W'(B_RECIP_LO);
        b_pp_reg[1] <= B_PP_W'(b_num_lo) * B_PP_W'(B_RECIP_HI);
        b_pp_reg[2] <= B_PP_W'(b_num_hi) * B_PP_W'(B_RECIP_LO);
        b_pp_reg[3] <= B_PP_W'(b_num_hi) * B_PP_W'(B_RECIP_HI);
        b_avg_reg   <= avg_reg;
    end

    // Average divided by 360, second stage: sum and take the quotient.
    assign b_sum = B_SUM_W'(b_pp_reg[0])
                 + (B_SUM_W'(b_pp_reg[1]) << B_HALF)
                 + (B_SUM_W'(b_pp_reg[2]) << B_HALF)
                 + (B_SUM_W'(b_pp_reg[3]) << B_PP_W);

    always_ff @(posedge clk)
    begin
        quot_reg  <= b_sum[B_SHIFT +: QUOT360_W];
        q_avg_reg <= b_avg_reg;
    end

    // Subtrahend: (average / 360) times the advance degrees.
    always_ff @(posedge clk)
    begin
        prod_reg  <= PROD_W'(quot_reg) * PROD_W'(advance_degrees);
        m_avg_reg <= q_avg_reg;
    end

    // Advance time saturates at zero.
    always_ff @(posedge clk)
    begin
        if (prod_reg > PROD_W'(m_avg_reg)) begin
            adv_reg <= '0;
        end else begin
            adv_reg <= m_avg_reg - prod_reg[TS_W-1:0];
        end
    end

    assign cmd_valid           = vld_reg[PIPE_LAT];
    assign cmd.tag             = tag_reg[PIPE_LAT];
    assign cmd.advance_time_us = adv_reg;

endmodule

// ===== hdl/iat_queue.sv =====
// ----------------------------------------------------------------------------
// Ignition advance timer queue
// Small FIFO between the advance unit and the firing back end.
// ----------------------------------------------------------------------------
module iat_queue
    import iat_pkg::*;
#(
    parameter int unsigned ADDR_W = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  iat_cmd_t push_data,
    input  logic     pop,
    output logic     head_valid,
    output iat_cmd_t head
);

    localparam int unsigned DEPTH = 2 ** ADDR_W;

    iat_cmd_t          entry_reg [DEPTH];
    logic [ADDR_W:0]   wr_ptr_reg;
    logic [ADDR_W:0]   rd_ptr_reg;

    // Pointers carry one wrap bit so that full and empty differ.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg[ADDR_W-1:0]] <= push_data;
        end
    end

    assign head_valid = (wr_ptr_reg != rd_ptr_reg);
    assign head       = entry_reg[rd_ptr_reg[ADDR_W-1:0]];

endmodule

// ===== hdl/iat_back.sv =====
// ----------------------------------------------------------------------------
// Ignition advance timer back end
// Applies the band rules to the ignition output and the last firing time,
// and holds the result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module iat_back
    import iat_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    input  iat_cmd_t cmd,
    output logic     cmd_pop,
    output logic     result_valid,
    input  logic     result_stall,
    output iat_out_t result
);

    logic            ign_reg;
    logic            ign_next;
    logic [TS_W-1:0] last_fire_reg;
    logic [TS_W-1:0] last_fire_next;
    logic            result_valid_reg;
    iat_out_t        result_reg;

    logic [TS_W-1:0] fire_time;
    logic            ign_held;

    // Take a queue entry whenever the output register is free or draining.
    assign cmd_pop = cmd_valid && (!result_valid_reg || !result_stall);

    // A high sensor level forces the output high before the band rules.
    assign ign_held  = cmd.tag.sensor_level | ign_reg;
    assign fire_time = last_fire_reg + cmd.advance_time_us;

    // Band rules.
    always_comb
    begin
        ign_next       = ign_held;
        last_fire_next = last_fire_reg;
        case (cmd.tag.speed_band)
            BAND_LOW: begin
                ign_next       = 1'b0;
                last_fire_next = cmd.tag.now_us;
            end
            BAND_TIMED: begin
                if (fire_time < cmd.tag.now_us) begin
                    ign_next       = 1'b0;
                    last_fire_next = cmd.tag.now_us;
                end else begin
                    ign_next = 1'b1;
                end
            end
            default: begin
                ign_next = ign_held;
            end
        endcase
    end

    // Firing state and output beat valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ign_reg          <= 1'b0;
            last_fire_reg    <= '0;
            result_valid_reg <= 1'b0;
        end else begin
            if (cmd_pop) begin
                ign_reg       <= ign_next;
                last_fire_reg <= last_fire_next;
            end
            if (cmd_pop) begin
                result_valid_reg <= 1'b1;
            end else if (!result_stall) begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd_pop) begin
            result_reg.ignition_level  <= ign_next;
            result_reg.speed_band      <= cmd.tag.speed_band;
            result_reg.advance_time_us <= cmd.advance_time_us;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hdl/ignition_advance_timer_unit.sv =====
// ----------------------------------------------------------------------------
// Ignition advance timer
// Hall sensor revolution timing with moving-average advance and speed bands.
// ----------------------------------------------------------------------------
// Usage:
// One sample beat per tick carries the hall level and a microsecond
// timestamp; every accepted sample yields exactly one result beat with the
// ignition level, the speed band and the current advance time, in order.
// The front end updates the period window and classifies the band in the
// cycle a sample is accepted. The advance unit then averages the window and
// scales it by the advance degrees in a pipeline of 6 stages: two for the
// average and two for the division by 360, both by reciprocal multiplication,
// one multiply and one saturating subtract. A 16-entry queue feeds the
// back end, which resolves the firing time combinationally and registers
// the result. One sample is taken every cycle when the receiver keeps up.
// sample_stall rises when the queue credits are used up, so a stalled
// result side backs up into the sample side without losing beats.
// Reset clears the window, the timing state and all beats in flight, and
// restores the register defaults. Configuration writes are always ready.
// ----------------------------------------------------------------------------
module ignition_advance_timer_unit
    import iat_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  iat_in_t              sample,
    output logic                 result_valid,
    input  logic                 result_stall,
    output iat_out_t             result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TS_W-1:0]      cfg_data
);

    localparam int unsigned TOTAL_W     = TS_W + $clog2(WINDOW_DEPTH);
    localparam int unsigned QUEUE_AW    = $clog2(ADV_PIPE_LAT + 4);
    localparam int unsigned QDEPTH      = 2 ** QUEUE_AW;
    localparam logic [QUEUE_AW:0] CREDIT_MAX = (QUEUE_AW + 1)'(QDEPTH);

    logic [TS_W-1:0]    low_band_reg;
    logic [TS_W-1:0]    limit_reg;
    logic [DEG_W-1:0]   advance_reg;
    logic [QUEUE_AW:0]  credit_reg;
    logic [QUEUE_AW:0]  credit_next;

    logic               sample_beat;
    logic               item_valid;
    iat_tag_t           item;
    logic [TOTAL_W-1:0] total;
    logic               cmd_valid;
    iat_cmd_t           cmd;
    logic               head_valid;
    iat_cmd_t           head;
    logic               head_pop;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            low_band_reg <= LOW_BAND_RESET;
            limit_reg    <= LIMIT_RESET;
            advance_reg  <= ADVANCE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_LOW_BAND: low_band_reg <= cfg_data;
                CFG_LIMIT:    limit_reg    <= cfg_data;
                CFG_ADVANCE:  advance_reg  <= cfg_data[DEG_W-1:0];
                default:      ;
            endcase
        end
    end

    // Credits cover every beat between the sample port and the queue head.
    assign sample_stall = (credit_reg == CREDIT_MAX);
    assign sample_beat  = sample_valid && !sample_stall;
    assign credit_next  = credit_reg + {{QUEUE_AW{1'b0}}, sample_beat}
                          - {{QUEUE_AW{1'b0}}, head_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

    // Front end: revolution timing and band classification.
    iat_front #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .TOTAL_W      (TOTAL_W)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_beat     (sample_beat),
        .sample          (sample),
        .low_band_period (low_band_reg),
        .limit_period    (limit_reg),
        .item_valid      (item_valid),
        .item            (item),
        .total           (total)
    );

    // Advance time pipeline.
    iat_adv #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .TOTAL_W      (TOTAL_W)
    ) u_adv (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item            (item),
        .total           (total),
        .advance_degrees (advance_reg),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd)
    );

    // Decoupling queue.
    iat_queue #(
        .ADDR_W (QUEUE_AW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_valid),
        .push_data  (cmd),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back end: firing decision and result register.
    iat_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (head_valid),
        .cmd          (head),
        .cmd_pop      (head_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== hdl/iat_checker.sv =====
// ----------------------------------------------------------------------------
// Ignition advance timer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module iat_checker
    import iat_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    input  logic                 sample_stall,
    input  iat_in_t              sample,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  iat_out_t             result,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TS_W-1:0]      cfg_data
);

    // A stalled result beat stays put.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // Only defined band codes are reported.
    a_band_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.speed_band == BAND_LOW ||
                          result.speed_band == BAND_TIMED ||
                          result.speed_band == BAND_LIMIT))
        else $error("undefined speed band");

    // The low band fires on every beat.
    a_low_fires: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.speed_band == BAND_LOW) |-> !result.ignition_level)
        else $error("ignition not fired in low band");

    // Leaving reset, nothing is pending and samples are taken.
    a_reset_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !result_valid && !sample_stall)
        else $error("beat pending or stall raised right after reset");

endmodule

bind ignition_advance_timer_unit iat_checker u_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ignition advance timer testbench
// Drives hall sensor revolutions with wrapping timestamps through the sample
// channel, predicts every result beat with a cycle-free model of the window,
// the advance time and the speed bands, and checks the result channel field
// by field. The sender bursts and pauses and the receiver stalls at random.
// ----------------------------------------------------------------------------
module testbench;
    import iat_pkg::*;

    localparam int WINDOW_DEPTH   = 5;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_SAMPLES  = 96;

    // Index outside the register file: writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    iat_in_t              sample       = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    iat_out_t             result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [TS_W-1:0]      cfg_data     = '0;

    // Predicted register values.
    logic [TS_W-1:0]  low_band_us;
    logic [TS_W-1:0]  limit_us;
    logic [DEG_W-1:0] adv_deg;

    // Predicted timing state.
    logic             armed_q;
    logic [TS_W-1:0]  edge_us;
    logic [TS_W-1:0]  band_period_us;
    logic [TS_W-1:0]  period_window [WINDOW_DEPTH];
    int unsigned      win_ptr;
    logic [34:0]      win_total;
    logic [TS_W-1:0]  last_fire_us;
    logic             ign_q;

    iat_out_t ignition_pending [$];
    int       mismatches   = 0;
    int       samples_sent = 0;
    int       burst_left   = 0;
    int       idle_cycles  = 0;
    int       stall_mode   = 0;
    int       stall_span   = 0;

    ignition_advance_timer_unit #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Return the prediction to its state after reset.
    task automatic reset_timer_state();
        low_band_us    = LOW_BAND_RESET;
        limit_us       = LIMIT_RESET;
        adv_deg        = ADVANCE_RESET;
        armed_q        = 1'b0;
        edge_us        = '0;
        band_period_us = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            period_window[i] = '0;
        end
        win_ptr      = 0;
        win_total    = '0;
        last_fire_us = '0;
        ign_q        = 1'b0;
    endtask

    // Advance the predicted timer by one sample and return the result beat.
    function automatic iat_out_t advance_timer_step(iat_in_t s);
        logic [TS_W-1:0] period_us;
        logic [63:0]     mean_us;
        logic [63:0]     retard_us;
        logic [TS_W-1:0] adv_us;
        logic [TS_W-1:0] fire_at_us;
        iat_out_t        r;
        // A low level after a high phase closes one revolution.
        if (!s.sensor_level)
        begin
            if (armed_q)
            begin
                period_us = s.now_us - edge_us;
                armed_q   = 1'b0;
                win_total = win_total - period_window[win_ptr] + period_us;
                period_window[win_ptr] = period_us;
                win_ptr   = (win_ptr == WINDOW_DEPTH - 1) ? 0 : win_ptr + 1;
                // A zero period enters the window but leaves the band alone.
                if (period_us != '0)
                    band_period_us = period_us;
                edge_us = s.now_us;
            end
        end
        else
        begin
            armed_q = 1'b1;
            ign_q   = 1'b1;
        end

        // Advance time saturates at zero when the retard exceeds the mean.
        mean_us   = 64'(win_total) / WINDOW_DEPTH;
        retard_us = (mean_us / 64'd360) * 64'(adv_deg);
        adv_us    = (retard_us > mean_us) ? '0 : TS_W'(mean_us - retard_us);

        // The low band test comes first, so it wins over a lower limit.
        if (band_period_us == '0 || band_period_us > low_band_us)
        begin
            r.speed_band = BAND_LOW;
            ign_q        = 1'b0;
            last_fire_us = s.now_us;
        end
        else if (band_period_us > limit_us)
        begin
            r.speed_band = BAND_TIMED;
            fire_at_us   = last_fire_us + adv_us;
            if (fire_at_us < s.now_us)
            begin
                ign_q        = 1'b0;
                last_fire_us = s.now_us;
            end
            else
            begin
                ign_q = 1'b1;
            end
        end
        else
        begin
            r.speed_band = BAND_LIMIT;
        end
        r.ignition_level  = ign_q;
        r.advance_time_us = adv_us;
        return r;
    endfunction

    // Check each result beat against the oldest prediction, then record
    // the prediction for each accepted sample beat.
    always @(posedge clk)
    begin
        iat_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (ignition_pending.size() == 0)
            begin
                $error("result beat with no sample outstanding: %h", result);
                mismatches++;
            end
            else
            begin
                want = ignition_pending.pop_front();
                if (result.ignition_level !== want.ignition_level)
                begin
                    $error("ignition_level: expected %0d, got %0d",
                           want.ignition_level, result.ignition_level);
                    mismatches++;
                end
                if (result.speed_band !== want.speed_band)
                begin
                    $error("speed_band: expected %0d, got %0d",
                           want.speed_band, result.speed_band);
                    mismatches++;
                end
                if (result.advance_time_us !== want.advance_time_us)
                begin
                    $error("advance_time_us: expected %0d, got %0d",
                           want.advance_time_us, result.advance_time_us);
                    mismatches++;
                end
            end
        end
        if (rst_n && sample_valid && !sample_stall)
            ignition_pending.push_back(advance_timer_step(sample));
    end

    // Receiver stalls in spans: never, now and then, or most of the time.
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_span <= $urandom_range(20, 200);
        end
        else
        begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 3) == 0);
            default: result_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // End the run if no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Send one sample beat; called and returning at a falling edge.
    task automatic send_sample(input iat_in_t beat);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        burst_left--;
        sample       <= beat;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (sample_stall);
        samples_sent++;
        @(negedge clk);
    endtask

    // Send one sample beat built from its fields.
    task automatic send_level(input logic level, input logic [TS_W-1:0] now);
        iat_in_t beat;
        beat.sensor_level = level;
        beat.now_us       = now;
        send_sample(beat);
    endtask

    // One revolution from the last closing time: some low ticks, some high
    // ticks spread over the period, then the closing low tick.
    task automatic run_revolution(input logic [TS_W-1:0] period_us,
                                  input int n_low, input int n_high);
        logic [TS_W-1:0] crank_us;
        logic [TS_W-1:0] step_us;
        logic [TS_W-1:0] offset_us;
        crank_us  = edge_us;
        step_us   = period_us / (n_low + n_high);
        offset_us = '0;
        for (int i = 0; i < n_low + n_high; i++)
        begin
            offset_us = offset_us + $urandom_range(0, step_us);
            send_level(i >= n_low, crank_us + offset_us);
        end
        send_level(1'b0, crank_us + period_us);
    endtask

    // Let every outstanding result drain before touching the registers.
    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (ignition_pending.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One register write; the caller lowers valid after its last write.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TS_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_LOW_BAND: low_band_us = data;
            CFG_LIMIT:    limit_us    = data;
            CFG_ADVANCE:  adv_deg     = data[DEG_W-1:0];
            default:      ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_config(input logic [TS_W-1:0] low_band, input logic [TS_W-1:0] limit,
                              input logic [TS_W-1:0] advance);
        wait_idle();
        cfg_write(CFG_LOW_BAND, low_band);
        cfg_write(CFG_LIMIT, limit);
        cfg_write(CFG_ADVANCE, advance);
        cfg_valid <= 1'b0;
    endtask

    // Period aimed at one of the bands of the current setting.
    function automatic logic [TS_W-1:0] pick_period();
        logic [TS_W-1:0] p;
        case ($urandom_range(0, 11))
            0:       p = '0;
            1:       p = $urandom;
            2, 3:    p = (limit_us == '0) ? '0 : $urandom_range(1, limit_us);
            4:       p = low_band_us + 1 + $urandom_range(0, 50000);
            5:
            begin
                case ($urandom_range(0, 3))
                    0:       p = limit_us;
                    1:       p = limit_us + 1;
                    2:       p = low_band_us;
                    default: p = low_band_us + 1;
                endcase
            end
            default:
            begin
                if (low_band_us > limit_us)
                    p = $urandom_range(limit_us + 1, low_band_us);
                else
                    p = $urandom;
            end
        endcase
        return p;
    endfunction

    // Reset defaults: idle low level, a wrapping first revolution, a zero
    // period, every band boundary and a few timed revolutions.
    task automatic test_startup_and_bands();
        send_level(1'b0, '0);
        send_level(1'b1, 32'hFFFF_FFFF);
        send_level(1'b0, 32'h0000_0005);
        run_revolution('0, 0, 1);
        run_revolution(32'd30001, 0, 1);
        run_revolution(32'd30000, 0, 1);
        run_revolution(32'd6667, 0, 1);
        run_revolution(32'd6666, 0, 1);
        repeat (2) run_revolution(32'd12000, 0, 2);
    endtask

    // A low band threshold below the limit: the low band test wins.
    task automatic test_register_order();
        set_config(32'd6000, 32'd20000, ADVANCE_RESET);
        cfg_write(CFG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
        run_revolution(32'd5000, 0, 1);
        run_revolution(32'd10000, 0, 1);
        run_revolution(32'd25000, 0, 1);
    endtask

    // Advance degrees of a full turn and beyond, up to saturation at zero.
    task automatic test_advance_underflow();
        set_config(LOW_BAND_RESET, LIMIT_RESET, 32'd360);
        repeat (3) run_revolution(32'd100000, 0, 1);
        set_config(LOW_BAND_RESET, LIMIT_RESET, 32'd511);
        run_revolution(32'd100000, 0, 1);
    endtask

    // Random revolutions with some noise, across several register settings.
    task automatic test_random_traffic();
        int phase_end;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: set_config(LOW_BAND_RESET, LIMIT_RESET, ADVANCE_RESET);
                1: set_config('1, '0, '0);
                2: set_config('0, '1, 32'd511);
                3: set_config('1, '1, 32'd359);
                4, 5:
                begin
                    phase_end = $urandom_range(8000, 60000);
                    set_config(phase_end, $urandom_range(1000, phase_end),
                               $urandom_range(0, 359));
                end
                default:
                begin
                    phase_end = $urandom_range(8000, 60000);
                    set_config(phase_end, $urandom_range(1000, phase_end), $urandom);
                end
            endcase
            phase_end = samples_sent + PHASE_SAMPLES;
            while (samples_sent < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_level(1'($urandom_range(0, 1)),
                               $urandom_range(0, 1) ? $urandom
                                                    : edge_us + $urandom_range(0, 40000));
                else
                    run_revolution(pick_period(), $urandom_range(0, 2), $urandom_range(1, 4));
            end
        end
    endtask

    initial
    begin
        reset_timer_state();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_startup_and_bands();
        test_register_order();
        test_advance_underflow();
        test_random_traffic();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && ignition_pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
